>>> rtl/rhgd_pkg.sv
// ----------------------------------------------------------------------------
// rhgd_pkg: shared definitions for the raise-hand gesture detector
// Register indexes, reset values, field widths and result codes.
// ----------------------------------------------------------------------------
package rhgd_pkg;

	// default width of one accelerometer axis
	localparam int ACCEL_WIDTH_DEF = 16;

	// motion sum and counter widths
	localparam int SUM_W  = 17;
	localparam int CNT_W  = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_MOTION_THR  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STILL_THR   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RUN_WINDOW  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SETTLE      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_UP_X_LIMIT  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_UP_Y_LIMIT  = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_DOWN_Y_LIM  = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_DOWN_X_FLR  = 3'd7;

	localparam logic [15:0] MOTION_THR_RST = 16'd18000;
	localparam logic [15:0] STILL_THR_RST  = 16'd1200;
	localparam logic [7:0]  RUN_WINDOW_RST = 8'd18;
	localparam logic [7:0]  SETTLE_RST     = 8'd3;
	localparam logic [14:0] UP_X_LIMIT_RST = 15'd3000;
	localparam logic [14:0] UP_Y_LIMIT_RST = 15'd10000;
	localparam logic [14:0] DOWN_Y_LIM_RST = 15'd4000;
	localparam logic [14:0] DOWN_X_FLR_RST = 15'd7000;

	// result codes
	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_UP   = 2'd1,
		GEST_DOWN = 2'd2
	} gesture_t;

	localparam int OUT_DATA_W = 8;

endpackage

>>> rtl/raise_hand_gesture_detector.sv
// ----------------------------------------------------------------------------
// raise_hand_gesture_detector: wrist raise / lower detection from x and y
// Tracks motion runs on a stream of accelerometer samples and reports hand-up
// or hand-down once the wrist settles in a matching pose.
// ----------------------------------------------------------------------------
// One sample goes in per transfer and exactly one gesture code comes out per
// sample, in order. A sample is first held in the input stage, where the
// motion sum, the change against the previous sum, the counter updates and
// the pose tests are worked out, and then waits in the output register until
// it is taken. With the output side ready the block takes one sample every
// cycle and presents each result from the output register; the only loop is
// the detector state (mode, last sum, two counters), which is updated in the
// same cycle that the result register loads. A failed sensor read
// (sample_valid low) yields code 0 and leaves the state alone. Configuration
// writes take effect at once and are meant for when no sample is in flight.
// ----------------------------------------------------------------------------
module raise_hand_gesture_detector #(
	parameter int ACCEL_WIDTH = rhgd_pkg::ACCEL_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// configuration write port
	input  logic                            cfg_we,
	input  logic [rhgd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rhgd_pkg::CFG_DATA_W-1:0] cfg_wdata,

	// sample stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [ACCEL_WIDTH-1:0] accel_x, [2*ACCEL_WIDTH-1:ACCEL_WIDTH] accel_y, zero pad
	input  logic [((2*ACCEL_WIDTH+7)/8)*8-1:0]   s_tdata,
	// [0] sample_valid
	input  logic                                 s_tuser,

	// gesture stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [1:0] gesture, zero pad
	output logic [rhgd_pkg::OUT_DATA_W-1:0]      m_tdata
);

	import rhgd_pkg::*;

	// wide enough for any magnitude, sum or limit
	localparam int CMP_W = (ACCEL_WIDTH > SUM_W) ? ACCEL_WIDTH : SUM_W;

	// configuration registers
	logic [15:0] motion_thr_q;
	logic [15:0] still_thr_q;
	logic [7:0]  run_window_q;
	logic [7:0]  settle_q;
	logic [14:0] up_x_limit_q;
	logic [14:0] up_y_limit_q;
	logic [14:0] down_y_lim_q;
	logic [14:0] down_x_flr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_thr_q <= MOTION_THR_RST;
			still_thr_q  <= STILL_THR_RST;
			run_window_q <= RUN_WINDOW_RST;
			settle_q     <= SETTLE_RST;
			up_x_limit_q <= UP_X_LIMIT_RST;
			up_y_limit_q <= UP_Y_LIMIT_RST;
			down_y_lim_q <= DOWN_Y_LIM_RST;
			down_x_flr_q <= DOWN_X_FLR_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MOTION_THR: motion_thr_q <= cfg_wdata;
				REG_STILL_THR:  still_thr_q  <= cfg_wdata;
				REG_RUN_WINDOW: run_window_q <= cfg_wdata[7:0];
				REG_SETTLE:     settle_q     <= cfg_wdata[7:0];
				REG_UP_X_LIMIT: up_x_limit_q <= cfg_wdata[14:0];
				REG_UP_Y_LIMIT: up_y_limit_q <= cfg_wdata[14:0];
				REG_DOWN_Y_LIM: down_y_lim_q <= cfg_wdata[14:0];
				REG_DOWN_X_FLR: down_x_flr_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the input stage advances whenever the output register is
	// empty or being drained; a waiting result blocks intake only once the
	// input stage is full as well.
	// ------------------------------------------------------------------
	logic                          valid_s1;
	logic                          smp_ok_s1;
	logic signed [ACCEL_WIDTH-1:0] x_s1;
	logic signed [ACCEL_WIDTH-1:0] y_s1;
	logic                          out_free;
	logic                          fire_s1;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign fire_s1  = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload: capture on every transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_ok_s1 <= s_tuser;
			x_s1      <= s_tdata[ACCEL_WIDTH-1:0];
			y_s1      <= s_tdata[2*ACCEL_WIDTH-1:ACCEL_WIDTH];
		end
	end

	// ------------------------------------------------------------------
	// Detector state
	// ------------------------------------------------------------------
	logic             running_q;
	logic [SUM_W-1:0] last_sum_q;
	logic [CNT_W-1:0] run_cnt_q;
	logic [CNT_W-1:0] still_cnt_q;

	// ------------------------------------------------------------------
	// Single-pass evaluation of the sample held in the input stage
	// ------------------------------------------------------------------
	logic [ACCEL_WIDTH-1:0] ax;
	logic [ACCEL_WIDTH-1:0] ay;
	logic [ACCEL_WIDTH:0]   sum_full;
	logic [SUM_W-1:0]       sum;
	logic [SUM_W-1:0]       diff;
	logic                   big_motion;
	logic                   still;
	logic [CNT_W-1:0]       run_inc;
	logic [CNT_W-1:0]       still_inc;
	logic                   timeout;
	logic                   settled;
	logic                   pose_up;
	logic                   pose_down;

	logic             running_d;
	logic [SUM_W-1:0] last_sum_d;
	logic [CNT_W-1:0] run_cnt_d;
	logic [CNT_W-1:0] still_cnt_d;
	gesture_t         gesture_d;

	always_comb begin
		// magnitudes; the most negative value maps onto the top bit
		ax = x_s1[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-x_s1) : ACCEL_WIDTH'(x_s1);
		ay = y_s1[ACCEL_WIDTH-1] ? ACCEL_WIDTH'(-y_s1) : ACCEL_WIDTH'(y_s1);
		sum_full = {1'b0, ax} + {1'b0, ay};
		sum      = SUM_W'(sum_full);
		diff     = (sum >= last_sum_q) ? (sum - last_sum_q) : (last_sum_q - sum);

		big_motion = sum > {1'b0, motion_thr_q};
		still      = diff < {1'b0, still_thr_q};

		// saturating counters
		run_inc   = (run_cnt_q   < CNT_MAX) ? run_cnt_q   + 1'b1 : run_cnt_q;
		still_inc = (still_cnt_q < CNT_MAX) ? still_cnt_q + 1'b1 : still_cnt_q;
		timeout   = run_inc   > {1'b0, run_window_q};
		settled   = still_inc > {1'b0, settle_q};

		// pose tests; y must be strictly positive for hand up
		pose_up   = (CMP_W'(ax) < CMP_W'(up_x_limit_q)) && !y_s1[ACCEL_WIDTH-1] &&
			(y_s1 != '0) && (CMP_W'(ACCEL_WIDTH'(y_s1)) < CMP_W'(up_y_limit_q));
		pose_down = (CMP_W'(ay) < CMP_W'(down_y_lim_q)) &&
			(CMP_W'(ax) > CMP_W'(down_x_flr_q));

		// hold by default
		running_d   = running_q;
		last_sum_d  = last_sum_q;
		run_cnt_d   = run_cnt_q;
		still_cnt_d = still_cnt_q;
		gesture_d   = GEST_NONE;

		if (smp_ok_s1) begin
			if (!running_q) begin
				// idle: remember the sum, start a run on big motion
				last_sum_d  = sum;
				running_d   = big_motion;
				run_cnt_d   = '0;
				still_cnt_d = '0;
			end else if (timeout) begin
				// window expired: drop back to idle, keep sum and still count
				run_cnt_d = run_inc;
				running_d = 1'b0;
			end else begin
				last_sum_d = sum;
				run_cnt_d  = run_inc;
				if (big_motion) begin
					// restart the window
					run_cnt_d   = '0;
					still_cnt_d = '0;
				end else if (still) begin
					still_cnt_d = still_inc;
					if (settled) begin
						priority if (pose_up) begin
							gesture_d = GEST_UP;
						end else if (pose_down) begin
							gesture_d = GEST_DOWN;
						end else begin
							running_d = 1'b0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			last_sum_q  <= '0;
			run_cnt_q   <= '0;
			still_cnt_q <= '0;
		end else if (fire_s1) begin
			running_q   <= running_d;
			last_sum_q  <= last_sum_d;
			run_cnt_q   <= run_cnt_d;
			still_cnt_q <= still_cnt_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	gesture_t gesture_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			gesture_q <= gesture_d;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-2){1'b0}}, gesture_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// an empty output register must never stall intake
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("intake stalled with empty output register");

	// a reported gesture leaves the detector running
	a_gesture_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (gesture_q != GEST_NONE)) |-> running_q)
		else $error("gesture reported while idle");

	// a reported gesture needs the settle count exceeded
	a_gesture_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (gesture_q != GEST_NONE)) |-> (still_cnt_q > {1'b0, settle_q}))
		else $error("gesture reported before settling");

endmodule
